// ----- hdl/ssa_pkg.sv -----
// Shared constants, codes and state encoding for the swap slot allocator.
package ssa_pkg;

    localparam int SLOT_W = 10;
    localparam int SECTOR_W = 13;
    localparam int CFG_W = 11;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    localparam int MAX_SLOTS_DEF = 1024;
    localparam int SECTORS_PER_SLOT_DEF = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NOT_IN_USE = 2'd1,
        ST_NONE_FREE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_EXEC
    } fsm_state_t;

endpackage

// ----- hdl/ssa_req_if.sv -----
// Request channel: action and slot index with valid/ready handshake.
interface ssa_req_if import ssa_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, output action, output slot_index, input ready);
    modport sink (input valid, input action, input slot_index, output ready);
endinterface

// ----- hdl/ssa_rsp_if.sv -----
// Response channel: slot, sector base, status and full flag with valid/ready handshake.
interface ssa_rsp_if import ssa_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector_base;
    logic [STATUS_W-1:0] status;
    logic                full_res;

    modport source (output valid, output slot, output sector_base, output status,
                    output full_res, input ready);
    modport sink (input valid, input slot, input sector_base, input status,
                  input full_res, output ready);
endinterface

// ----- hdl/swap_slot_allocator_core.sv -----
// Top level of the swap slot allocator: control, free queue and in-use table.
// A request word is taken in IDLE, where the in-use table and free queue head are
// read from their RAMs; in EXEC it is modified, written back and loaded into the
// response register. A new request is taken while a finished response still waits;
// the modify step stalls only if that response has not yet been taken. After reset
// the in-use table is swept clear, one entry per cycle, over all MAX_SLOTS entries
// (1024 by default) with req.ready low; configuration writes are taken throughout.
// Allocation pops the oldest freed slot, otherwise the next never-used slot
// below min(swap_slots, MAX_SLOTS); full_res reports that neither remains.
module swap_slot_allocator_core import ssa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int SECTORS_PER_SLOT = SECTORS_PER_SLOT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    ssa_req_if.sink          req,
    ssa_rsp_if.source        rsp
);

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int LW = (CW > CFG_W) ? CW : CFG_W;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    logic [CFG_W-1:0]  swap_slots_reg;
    logic [AW-1:0]     clr_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [AW-1:0]     tail_reg;
    logic [AW-1:0]     tail_next;
    logic [CW-1:0]     free_count_reg;
    logic [CW-1:0]     free_count_next;
    logic [CW-1:0]     next_unused_reg;
    logic [CW-1:0]     next_unused_next;
    logic [ACTION_W-1:0] action_reg;
    logic [SLOT_W-1:0] idx_reg;

    logic              rsp_valid_reg;
    logic [SLOT_W-1:0] rsp_slot_reg;
    logic [SLOT_W-1:0] rsp_slot_next;
    logic [SECTOR_W-1:0] rsp_sector_reg;
    status_t           rsp_status_reg;
    status_t           rsp_status_next;
    logic              rsp_full_reg;
    logic              rsp_full_next;

    logic              clearing;
    logic              exec_active;
    logic              exec_done;
    logic              clear_last;
    logic              in_range;
    logic [LW-1:0]     limit;
    logic [LW-1:0]     swap_ext;
    logic [LW-1:0]     max_ext;

    logic              use_rd;
    logic              use_we;
    logic [AW-1:0]     use_waddr;
    logic              use_wdata;
    logic [AW-1:0]     use_raddr;
    logic              use_ram_we;
    logic [AW-1:0]     use_ram_waddr;
    logic              use_ram_wdata;

    logic [AW-1:0]     q_rd;
    logic              q_we;

    ssa_ram #(.DEPTH(MAX_SLOTS), .WIDTH(1)) u_in_use (
        .clk   (clk),
        .we    (use_ram_we),
        .waddr (use_ram_waddr),
        .wdata (use_ram_wdata),
        .raddr (use_raddr),
        .rdata (use_rd)
    );

    ssa_ram #(.DEPTH(MAX_SLOTS), .WIDTH(AW)) u_free_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg),
        .wdata (AW'(idx_reg)),
        .raddr (head_reg),
        .rdata (q_rd)
    );

    assign clear_last = (clr_reg == AW'(MAX_SLOTS - 1));
    assign swap_ext = LW'(swap_slots_reg);
    assign max_ext = LW'(MAX_SLOTS);
    assign limit = (swap_ext < max_ext) ? swap_ext : max_ext;
    assign in_range = (32'(idx_reg) < MAX_SLOTS);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        clearing = 1'b0;
        exec_active = 1'b0;
        case (state_reg)
            FSM_CLEAR: clearing = 1'b1;
            FSM_IDLE:  req.ready = 1'b1;
            FSM_EXEC:  exec_active = 1'b1;
            default:   clearing = 1'b0;
        endcase
    end

    assign exec_done = exec_active && (!rsp_valid_reg || rsp.ready);
    assign use_raddr = (state_reg == FSM_IDLE) ? AW'(req.slot_index) : AW'(idx_reg);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        free_count_next = free_count_reg;
        next_unused_next = next_unused_reg;
        use_we = 1'b0;
        use_waddr = AW'(idx_reg);
        use_wdata = 1'b0;
        q_we = 1'b0;
        rsp_slot_next = idx_reg;
        rsp_status_next = ST_OK;
        if (action_reg == ACT_ALLOC)
        begin
            if (free_count_reg != '0)
            begin
                rsp_slot_next = SLOT_W'(q_rd);
                use_we = 1'b1;
                use_waddr = q_rd;
                use_wdata = 1'b1;
                head_next = (head_reg == AW'(MAX_SLOTS - 1)) ? '0 : head_reg + 1'b1;
                free_count_next = free_count_reg - 1'b1;
            end
            else if (LW'(next_unused_reg) < limit)
            begin
                rsp_slot_next = SLOT_W'(next_unused_reg);
                use_we = 1'b1;
                use_waddr = AW'(next_unused_reg);
                use_wdata = 1'b1;
                next_unused_next = next_unused_reg + 1'b1;
            end
            else
            begin
                rsp_slot_next = '0;
                rsp_status_next = ST_NONE_FREE;
            end
        end
        else if (!in_range || !use_rd)
        begin
            rsp_status_next = ST_NOT_IN_USE;
        end
        else if (action_reg == ACT_FREE)
        begin
            use_we = 1'b1;
            if (free_count_reg < CW'(MAX_SLOTS))
            begin
                q_we = exec_done;
                tail_next = (tail_reg == AW'(MAX_SLOTS - 1)) ? '0 : tail_reg + 1'b1;
                free_count_next = free_count_reg + 1'b1;
            end
        end
        rsp_full_next = (free_count_next == '0) && (LW'(next_unused_next) >= limit);
    end

    assign use_ram_we = clearing || (exec_done && use_we);
    assign use_ram_waddr = clearing ? clr_reg : use_waddr;
    assign use_ram_wdata = clearing ? 1'b0 : use_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_CLEAR;
            swap_slots_reg <= CFG_W'(1024);
            clr_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            free_count_reg <= '0;
            next_unused_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                swap_slots_reg <= cfg_wdata;
            end
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (exec_done)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                free_count_reg <= free_count_next;
                next_unused_reg <= next_unused_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            action_reg <= req.action;
            idx_reg <= req.slot_index;
        end
        if (exec_done)
        begin
            rsp_slot_reg <= rsp_slot_next;
            rsp_sector_reg <= SECTOR_W'({3'b000, rsp_slot_next} * SECTOR_W'(SECTORS_PER_SLOT));
            rsp_status_reg <= rsp_status_next;
            rsp_full_reg <= rsp_full_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.slot = rsp_slot_reg;
    assign rsp.sector_base = rsp_sector_reg;
    assign rsp.status = rsp_status_reg;
    assign rsp.full_res = rsp_full_reg;

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !(req.valid && req.ready))
        else $error("request taken during in-use clear");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= CW'(MAX_SLOTS))
        else $error("free count beyond queue depth");

    a_none_free_is_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_NONE_FREE) |-> rsp.full_res)
        else $error("allocation refused without full flag");

    a_bump_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> next_unused_reg >= $past(next_unused_reg))
        else $error("bump counter went backwards");

    a_one_pop_or_bump: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_done && free_count_reg != '0 && action_reg == ACT_ALLOC)
            |=> $stable(next_unused_reg))
        else $error("bump counter moved while freed slot available");

endmodule

// ----- hdl/ssa_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module ssa_ram import ssa_pkg::*;
#(
    parameter int DEPTH = MAX_SLOTS_DEF,
    parameter int WIDTH = SLOT_W
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
